[sv/fffr_pkg.sv]
package fffr_pkg;

	// Value positions, tree node indexes and stored gaps.
	localparam int POS_W = 12;
	localparam int NODE_W = POS_W + 1;
	localparam int GAP_W = 13;
	localparam int ALU_W = 14;
	localparam int TREE_DEPTH = 1 << NODE_W;

	localparam logic [GAP_W-1:0] GAP_FULL = 13'd4096;
	localparam logic [NODE_W-1:0] ROOT_NODE = 13'd1;

	// Request types.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;
	localparam logic [1:0] REQ_RESERVED = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_UPDATE = 2'd0;
	localparam logic [1:0] STAT_QUERY = 2'd1;
	localparam logic [1:0] STAT_REJECT = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [11:0] element;
		logic [12:0] run_length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [12:0] answer;
	} result_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MAX
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEAF_RD,
		ST_LEAF_CHK,
		ST_CLIMB_RD,
		ST_CLIMB_CHK,
		ST_DESC_RD,
		ST_DESC_CHK,
		ST_GAPD_RD,
		ST_GAPD_CHK,
		ST_PUT_LEAF,
		ST_UP_RD,
		ST_UP_WR,
		ST_Q_ROOT_RD,
		ST_Q_ROOT_CHK,
		ST_Q_RD,
		ST_Q_CHK
	} state_t;

endpackage

[sv/fffr_ram.sv]
module fffr_ram #(
	parameter int WIDTH = 13,
	parameter int DEPTH = 8192
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/fffr_alu.sv]
module fffr_alu
	import fffr_pkg::*;
(
	input alu_op_t op,
	input logic [ALU_W-1:0] a,
	input logic [ALU_W-1:0] b,
	output logic [ALU_W-1:0] res,
	output logic ge
);

	// Shared adder and comparator; the compare also selects the maximum.
	always_comb begin
		ge = (a >= b);
		case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
			ALU_MAX: res = ge ? a : b;
			default: res = '0;
		endcase
	end

endmodule

[sv/first_fit_free_run_set.sv]
// Set of values 1..4095 with a first-fit free-run search.
// Input: a request word is taken at a rising edge where start is high and
// busy is low. It holds a request type (insert, remove or query), the
// element to insert or remove, and the run length sought by a query.
// Output: exactly one result word per request, shown on result for one
// cycle while done is high. The receiver cannot stall; it must take it.
// Each request is handled alone and busy stays high until its result;
// a request rejected at intake never raises busy. A query walks a max
// tree of gaps from the root to a leaf. An insert or remove reads the
// leaf, searches the tree for the predecessor, then rewrites two leaves
// and their ancestor paths. All tree traffic goes through the one tree
// memory, one read and one write per cycle, and its registered read
// splits each tree level into a read step and a check step. Rejected
// requests finish at intake, after the leaf read or after the root read.
// After reset the block sweeps the tree memory once, all 8192 nodes, to
// set its start contents; busy is high during that pass.
module first_fit_free_run_set
	import fffr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input req_t req,
	output logic done,
	output result_t result
);

	state_t state_q, state_d;
	req_t req_q, req_d;
	logic [ALU_W-1:0] need_q, need_d;
	logic [NODE_W-1:0] node_q, node_d;
	logic [GAP_W-1:0] val_q, val_d;
	logic [POS_W-1:0] down_q, down_d;
	logic [GAP_W-1:0] up_q, up_d;
	logic phase_q, phase_d;
	logic [NODE_W-1:0] clr_q, clr_d;
	logic done_q, done_d;
	result_t res_q, res_d;

	logic we;
	logic [NODE_W-1:0] waddr;
	logic [GAP_W-1:0] wdata;
	logic [NODE_W-1:0] raddr;
	logic [GAP_W-1:0] rdata;
	alu_op_t op;
	logic [ALU_W-1:0] alu_a, alu_b, alu_res;
	logic alu_ge;
	logic is_insert;
	logic [POS_W-1:0] put_pos;

	fffr_ram #(
		.WIDTH(GAP_W),
		.DEPTH(TREE_DEPTH)
	) u_tree (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	fffr_alu u_alu (
		.op(op),
		.a(alu_a),
		.b(alu_b),
		.res(alu_res),
		.ge(alu_ge)
	);

	assign is_insert = (req_q.req_type == REQ_INSERT);
	assign put_pos = phase_q ? down_q : req_q.element;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = res_q;

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			done_q <= done_d;
			phase_q <= phase_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		req_q <= req_d;
		need_q <= need_d;
		node_q <= node_d;
		val_q <= val_d;
		down_q <= down_d;
		up_q <= up_d;
		res_q <= res_d;
	end

	// Sequencer: next state, memory controls and shared unit operands.
	always_comb begin
		state_d = state_q;
		req_d = req_q;
		need_d = need_q;
		node_d = node_q;
		val_d = val_q;
		down_d = down_q;
		up_d = up_q;
		phase_d = phase_q;
		clr_d = clr_q;
		done_d = 1'b0;
		res_d = res_q;
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		op = ALU_ADD;
		alu_a = '0;
		alu_b = '0;
		case (state_q)
			ST_CLEAR: begin
				// Nodes on the path to leaf zero hold the full gap.
				we = 1'b1;
				waddr = clr_q;
				wdata = $onehot(clr_q) ? GAP_FULL : '0;
				clr_d = clr_q + 1'b1;
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				op = ALU_ADD;
				alu_a = {1'b0, req.run_length};
				alu_b = 14'd1;
				if (start) begin
					req_d = req;
					need_d = alu_res;
					case (req.req_type)
						REQ_INSERT, REQ_REMOVE: begin
							if (req.element == '0) begin
								done_d = 1'b1;
								res_d.status = STAT_REJECT;
								res_d.answer = '0;
							end else begin
								state_d = ST_LEAF_RD;
							end
						end
						REQ_QUERY: state_d = ST_Q_ROOT_RD;
						default: begin
							done_d = 1'b1;
							res_d.status = STAT_REJECT;
							res_d.answer = '0;
						end
					endcase
				end
			end
			ST_LEAF_RD: begin
				raddr = {1'b1, req_q.element};
				state_d = ST_LEAF_CHK;
			end
			ST_LEAF_CHK: begin
				// A nonzero leaf gap marks a member.
				op = ALU_ADD;
				alu_a = {2'b0, req_q.element};
				alu_b = {1'b0, rdata};
				node_d = {1'b1, req_q.element};
				if (is_insert == (rdata != '0)) begin
					done_d = 1'b1;
					res_d.status = STAT_REJECT;
					res_d.answer = '0;
					state_d = ST_IDLE;
				end else begin
					up_d = alu_res[GAP_W-1:0];
					state_d = ST_CLIMB_RD;
				end
			end
			ST_CLIMB_RD: begin
				// Climb until a left sibling holds some member.
				if (node_q[0]) begin
					raddr = {node_q[NODE_W-1:1], 1'b0};
					state_d = ST_CLIMB_CHK;
				end else begin
					node_d = {1'b0, node_q[NODE_W-1:1]};
				end
			end
			ST_CLIMB_CHK: begin
				if (rdata != '0) begin
					node_d = {node_q[NODE_W-1:1], 1'b0};
					state_d = ST_DESC_RD;
				end else begin
					node_d = {1'b0, node_q[NODE_W-1:1]};
					state_d = ST_CLIMB_RD;
				end
			end
			ST_DESC_RD: begin
				// Descend to the rightmost member of the subtree.
				if (node_q[NODE_W-1]) begin
					down_d = node_q[POS_W-1:0];
					phase_d = 1'b0;
					state_d = is_insert ? ST_GAPD_RD : ST_PUT_LEAF;
				end else begin
					raddr = {node_q[POS_W-1:0], 1'b1};
					state_d = ST_DESC_CHK;
				end
			end
			ST_DESC_CHK: begin
				node_d = {node_q[POS_W-1:0], rdata != '0};
				state_d = ST_DESC_RD;
			end
			ST_GAPD_RD: begin
				raddr = {1'b1, down_q};
				state_d = ST_GAPD_CHK;
			end
			ST_GAPD_CHK: begin
				// The successor of an absent element ends its predecessor's gap.
				op = ALU_ADD;
				alu_a = {2'b0, down_q};
				alu_b = {1'b0, rdata};
				up_d = alu_res[GAP_W-1:0];
				state_d = ST_PUT_LEAF;
			end
			ST_PUT_LEAF: begin
				op = ALU_SUB;
				if (!phase_q) begin
					alu_a = is_insert ? {1'b0, up_q} : {2'b0, req_q.element};
					alu_b = {2'b0, req_q.element};
				end else begin
					alu_a = is_insert ? {2'b0, req_q.element} : {1'b0, up_q};
					alu_b = {2'b0, down_q};
				end
				we = 1'b1;
				waddr = {1'b1, put_pos};
				wdata = alu_res[GAP_W-1:0];
				val_d = alu_res[GAP_W-1:0];
				node_d = {1'b1, put_pos};
				state_d = ST_UP_RD;
			end
			ST_UP_RD: begin
				raddr = {node_q[NODE_W-1:1], ~node_q[0]};
				state_d = ST_UP_WR;
			end
			ST_UP_WR: begin
				// Parent takes the larger of the two children.
				op = ALU_MAX;
				alu_a = {1'b0, val_q};
				alu_b = {1'b0, rdata};
				we = 1'b1;
				waddr = {1'b0, node_q[NODE_W-1:1]};
				wdata = alu_res[GAP_W-1:0];
				val_d = alu_res[GAP_W-1:0];
				node_d = {1'b0, node_q[NODE_W-1:1]};
				if ({1'b0, node_q[NODE_W-1:1]} == ROOT_NODE) begin
					if (!phase_q) begin
						phase_d = 1'b1;
						state_d = ST_PUT_LEAF;
					end else begin
						done_d = 1'b1;
						res_d.status = STAT_UPDATE;
						res_d.answer = '0;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_UP_RD;
				end
			end
			ST_Q_ROOT_RD: begin
				raddr = ROOT_NODE;
				state_d = ST_Q_ROOT_CHK;
			end
			ST_Q_ROOT_CHK: begin
				alu_a = {1'b0, rdata};
				alu_b = need_q;
				node_d = ROOT_NODE;
				if (alu_ge) begin
					state_d = ST_Q_RD;
				end else begin
					done_d = 1'b1;
					res_d.status = STAT_REJECT;
					res_d.answer = '0;
					state_d = ST_IDLE;
				end
			end
			ST_Q_RD: begin
				// At a leaf, the run starts one past that member.
				op = ALU_ADD;
				alu_a = {2'b0, node_q[POS_W-1:0]};
				alu_b = 14'd1;
				if (node_q[NODE_W-1]) begin
					done_d = 1'b1;
					res_d.status = STAT_QUERY;
					res_d.answer = alu_res[GAP_W-1:0];
					state_d = ST_IDLE;
				end else begin
					raddr = {node_q[POS_W-1:0], 1'b0};
					state_d = ST_Q_CHK;
				end
			end
			ST_Q_CHK: begin
				alu_a = {1'b0, rdata};
				alu_b = need_q;
				node_d = {node_q[POS_W-1:0], ~alu_ge};
				state_d = ST_Q_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	// A result is only ever shown once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Only query answers carry a nonzero answer.
	a_answer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_QUERY) |-> (result.answer == '0))
		else $error("nonzero answer on a non-query result");

	// After the clearing pass, node zero of the tree is never written.
	a_no_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q != ST_CLEAR) |-> (waddr != '0))
		else $error("write to unused tree node");

	// A taken query is never rejected at once; it keeps the block busy.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.req_type == REQ_QUERY) |=> (busy && !done))
		else $error("query finished without tree walk");
`endif

endmodule
